>>> design/stp_pkg.sv
// shared types, codes and helpers for the string to int32 parser
`default_nettype none

package stp_pkg;

   // parse phase codes
   localparam logic [2:0] PH_SPACES = 3'd0;
   localparam logic [2:0] PH_MINUS  = 3'd1;
   localparam logic [2:0] PH_PREFIX = 3'd2;
   localparam logic [2:0] PH_ZERO   = 3'd3;
   localparam logic [2:0] PH_DIGITS = 3'd4;
   localparam logic [2:0] PH_DONE   = 3'd5;

   // register map
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [0:0] CSR_RADIX_IDX = 1'b0;

   localparam int unsigned CH_W    = 8;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned BASE_W  = 6;

   localparam logic [VALUE_W-1:0] NEG_LIMIT = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] POS_LIMIT = 32'h7fff_ffff;

   // digit code that is never below any base
   localparam logic [BASE_W-1:0] NOT_DIGIT = 6'd63;

   // characters of interest
   localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
   localparam logic [CH_W-1:0] CH_PLUS  = 8'h2b;
   localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
   localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7a;
   localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
   localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5a;
   localparam logic [CH_W-1:0] CH_LO_X  = 8'h78;
   localparam logic [CH_W-1:0] CH_UP_X  = 8'h58;

   // one finished conversion from the parse step
   typedef struct packed {
      logic               hit;
      logic [VALUE_W-1:0] value;
      logic               overflowed;
   } result_type;

   // value of a character as a digit, NOT_DIGIT when it is none
   function automatic logic [BASE_W-1:0] digit_value(input logic [CH_W-1:0] c);
      logic [CH_W-1:0] diff;
      begin
         diff = '0;
         if (c >= CH_ZERO && c <= CH_NINE) begin
            diff = c - CH_ZERO;
            digit_value = diff[BASE_W-1:0];
         end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            diff = c - CH_LO_A + 8'd10;
            digit_value = diff[BASE_W-1:0];
         end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            diff = c - CH_UP_A + 8'd10;
            digit_value = diff[BASE_W-1:0];
         end else begin
            digit_value = NOT_DIGIT;
         end
      end
   endfunction

endpackage

`default_nettype wire

>>> design/stp_csr.sv
// configuration register block with apb-style access
`default_nettype none

module stp_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [stp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [31:0]                      csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready,
   output logic [stp_pkg::BASE_W-1:0]            radix
);

   logic [stp_pkg::BASE_W-1:0] radix_ff;
   logic [stp_pkg::BASE_W-1:0] radix_in;
   logic                       wr_radix;

   assign csr_pready = 1'b1;

   // write decode on the access cycle
   assign wr_radix = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                     (csr_paddr[2] == stp_pkg::CSR_RADIX_IDX);

   assign radix_in = wr_radix ? csr_pwdata[stp_pkg::BASE_W-1:0] : radix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= '0;
      end else begin
         radix_ff <= radix_in;
      end
   end

   // read mux
   always_comb begin
      unique case (csr_paddr[2])
         stp_pkg::CSR_RADIX_IDX: csr_prdata = {{(32-stp_pkg::BASE_W){1'b0}}, radix_ff};
         default:                csr_prdata = '0;
      endcase
   end

   assign radix = radix_ff;

endmodule

`default_nettype wire

>>> design/stp_parse.sv
// per-character parse step with its phase, sign, base and accumulator state
`default_nettype none

module stp_parse (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step_en,
   input  wire logic [stp_pkg::CH_W-1:0]      ch,
   input  wire logic                          first,
   input  wire logic [stp_pkg::BASE_W-1:0]    radix,
   output stp_pkg::result_type                result
);

   logic [2:0]                    phase_ff, phase_in;
   logic                          neg_ff, neg_in;
   logic [stp_pkg::VALUE_W-1:0]   acc_ff, acc_in;
   logic                          ovf_ff, ovf_in;
   logic [stp_pkg::BASE_W-1:0]    base_ff, base_in;

   // state seen by this item after a possible restart
   logic [2:0]                    ph_cur;
   logic                          neg_cur;
   logic [stp_pkg::VALUE_W-1:0]   acc_cur;
   logic                          ovf_cur;
   logic [stp_pkg::BASE_W-1:0]    base_cur;

   logic                          do_prefix;
   logic                          do_digit;
   logic [stp_pkg::BASE_W-1:0]    dval;
   logic [37:0]                   acc_next;
   logic [32:0]                   limit;

   assign dval = stp_pkg::digit_value(ch);

   always_comb begin
      // restart on a first-flagged item
      if (first) begin
         ph_cur   = stp_pkg::PH_SPACES;
         neg_cur  = 1'b0;
         acc_cur  = '0;
         ovf_cur  = 1'b0;
         base_cur = radix;
      end else begin
         ph_cur   = phase_ff;
         neg_cur  = neg_ff;
         acc_cur  = acc_ff;
         ovf_cur  = ovf_ff;
         base_cur = base_ff;
      end

      phase_in  = ph_cur;
      neg_in    = neg_cur;
      acc_in    = acc_cur;
      ovf_in    = ovf_cur;
      base_in   = base_cur;
      do_prefix = 1'b0;
      do_digit  = 1'b0;
      result    = '0;
      acc_next  = '0;
      limit     = '0;

      // sign and prefix handling
      unique case (ph_cur)
         stp_pkg::PH_SPACES: begin
            if (ch == stp_pkg::CH_MINUS) begin
               neg_in   = 1'b1;
               phase_in = stp_pkg::PH_MINUS;
            end else if (ch == stp_pkg::CH_PLUS) begin
               phase_in = stp_pkg::PH_PREFIX;
            end else if (ch != stp_pkg::CH_SPACE) begin
               do_prefix = 1'b1;
            end
         end
         stp_pkg::PH_MINUS: begin
            if (ch == stp_pkg::CH_PLUS) begin
               phase_in = stp_pkg::PH_PREFIX;
            end else begin
               do_prefix = 1'b1;
            end
         end
         stp_pkg::PH_PREFIX: begin
            do_prefix = 1'b1;
         end
         stp_pkg::PH_ZERO: begin
            phase_in = stp_pkg::PH_DIGITS;
            if (ch == stp_pkg::CH_LO_X || ch == stp_pkg::CH_UP_X) begin
               base_in = 6'd16;
            end else begin
               if (base_cur == '0) base_in = 6'd8;
               acc_in   = '0;
               do_digit = 1'b1;
            end
         end
         stp_pkg::PH_DIGITS: begin
            do_digit = 1'b1;
         end
         default: begin
         end
      endcase

      // leading zero may open a hex prefix or select octal
      if (do_prefix) begin
         if ((base_cur == '0 || base_cur == 6'd16) && ch == stp_pkg::CH_ZERO) begin
            phase_in = stp_pkg::PH_ZERO;
         end else begin
            if (base_cur == '0) base_in = 6'd10;
            phase_in = stp_pkg::PH_DIGITS;
            do_digit = 1'b1;
         end
      end

      // digit accumulate or finish on a non-digit
      if (do_digit) begin
         if (dval >= base_in) begin
            phase_in   = stp_pkg::PH_DONE;
            result.hit = 1'b1;
            if (ovf_in) begin
               result.value      = neg_in ? stp_pkg::NEG_LIMIT : stp_pkg::POS_LIMIT;
               result.overflowed = 1'b1;
            end else begin
               result.value      = neg_in ? (32'd0 - acc_in) : acc_in;
               result.overflowed = 1'b0;
            end
         end else if (!ovf_in) begin
            acc_next = {6'd0, acc_in} * {32'd0, base_in} + {32'd0, dval};
            limit    = {1'b0, (neg_in ? stp_pkg::NEG_LIMIT : stp_pkg::POS_LIMIT)};
            if (acc_next > {5'd0, limit}) begin
               ovf_in = 1'b1;
            end else begin
               acc_in = acc_next[stp_pkg::VALUE_W-1:0];
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= stp_pkg::PH_DONE;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
         ovf_ff   <= 1'b0;
         base_ff  <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
         ovf_ff   <= ovf_in;
         base_ff  <= base_in;
      end
   end

endmodule

`default_nettype wire

>>> design/string_to_int32_parser_core.sv
// top level of the streaming string to int32 parser
//
//   port group  dir  contents
//   req_*       in   tdata = ch[7:0], tuser = first
//   rsp_*       out  tdata = value[31:0] (signed), tuser = overflowed
//   csr_*       in   radix at byte address 0, apb-style
//
// an item is registered on accept, then parsed; one item per cycle unless stalled
// a result is loaded into the output register as its terminating item is parsed
// the only loop is the parse state update, one multiply-add and compare per cycle
// reset clears the parse to the done phase and empties both registers
// a stalled result holds the parse stage; the input stays open while the input
// register is empty or its item moves on
`default_nettype none

module string_to_int32_parser_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input items
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,   // ch[7:0]
   input  wire logic                            req_tuser,   // first
   // result items
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [31:0]                          rsp_tdata,   // value[31:0]
   output logic                                 rsp_tuser,   // overflowed
   // configuration
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [stp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);

   logic                          s1_valid_ff, s1_valid_in;
   logic [stp_pkg::CH_W-1:0]      s1_ch_ff, s1_ch_in;
   logic                          s1_first_ff, s1_first_in;
   logic                          s1_advance;
   logic                          req_fire;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [stp_pkg::VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                          rsp_ovf_ff, rsp_ovf_in;

   logic [stp_pkg::BASE_W-1:0]    radix;
   stp_pkg::result_type           result;

   stp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .radix       (radix)
   );

   stp_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step_en (s1_advance),
      .ch      (s1_ch_ff),
      .first   (s1_first_ff),
      .radix   (radix),
      .result  (result)
   );

   // handshake between the stages
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_fire   = req_tvalid && req_tready;

   // input register
   assign s1_valid_in = req_fire ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
   assign s1_ch_in    = req_fire ? req_tdata : s1_ch_ff;
   assign s1_first_in = req_fire ? req_tuser : s1_first_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ch_ff    <= s1_ch_in;
      s1_first_ff <= s1_first_in;
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (s1_advance && result.hit) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = result.value;
         rsp_ovf_in   = result.overflowed;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   // saturated results carry one of the two limits
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ovf_ff |->
         (rsp_value_ff == stp_pkg::NEG_LIMIT || rsp_value_ff == stp_pkg::POS_LIMIT))
      else $error("overflowed result without a saturated value");

   // a new result only follows a parse step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_advance))
      else $error("result appeared without a parse step");

   // a held input item stays until it is parsed
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(s1_ch_ff))
      else $error("input item lost while stalled");

   // reset empties both registers
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
